### rtl/core/leg_forward_kinematics_jacobian_defines.svh
// Assertion macros for the leg kinematics block.
// Used by rtl/core modules that carry checks; no other dependencies.
`ifndef LEG_FORWARD_KINEMATICS_JACOBIAN_DEFINES_SVH
`define LEG_FORWARD_KINEMATICS_JACOBIAN_DEFINES_SVH

// Implication checked in the next cycle
`define LFKJ_ASSERT_NEXT(label, clk, rst_n, a, c, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);

// Implication checked in the same cycle
`define LFKJ_ASSERT_NOW(label, clk, rst_n, a, c, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);

`endif

### rtl/core/lfkj_pkg.sv
// Shared types and constants for the leg kinematics pipeline.
// No dependencies.
package lfkj_pkg;

    localparam int CordicSteps = 16;
    localparam int TrigLat     = CordicSteps + 2;
    localparam int KinLat      = 6;

    localparam logic signed [20:0] AngPi     = 21'sd205887;
    localparam logic signed [20:0] AngHalfPi = 21'sd102944;
    localparam logic signed [33:0] CordicGain = 34'sd652032874;

    // Register indexes
    localparam logic [2:0] RegBaseHeight  = 3'd0;
    localparam logic [2:0] RegUpperOffset = 3'd1;
    localparam logic [2:0] RegSideOffset  = 3'd2;
    localparam logic [2:0] RegThighLength = 3'd3;
    localparam logic [2:0] RegShankLength = 3'd4;

    typedef struct packed {
        logic signed [15:0] hip_angle;
        logic signed [15:0] pitch_angle;
        logic signed [15:0] knee_angle;
    } in_beat_t;

    typedef struct packed {
        logic signed [23:0] foot_x;
        logic signed [23:0] foot_y;
        logic signed [23:0] foot_z;
        logic signed [23:0] jac_r1c1;
        logic signed [23:0] jac_r1c2;
        logic signed [23:0] jac_r1c3;
        logic signed [23:0] jac_r2c1;
        logic signed [23:0] jac_r2c2;
        logic signed [23:0] jac_r2c3;
        logic signed [23:0] jac_r3c2;
        logic signed [23:0] jac_r3c3;
    } out_beat_t;

    typedef struct packed {
        logic signed [15:0] sn;
        logic signed [15:0] cs;
    } trig_t;

    typedef struct packed {
        logic signed [19:0] base_height;
        logic signed [19:0] upper_offset;
        logic signed [19:0] side_offset;
        logic signed [19:0] thigh_length;
        logic signed [19:0] shank_length;
    } geom_t;

    // Arctangent of 2^-i in units of 2^-16 rad
    function automatic logic signed [20:0] atan_step(input logic [3:0] i);
        logic signed [20:0] r;
        unique case (i)
            4'd0:  r = 21'sd51472;
            4'd1:  r = 21'sd30386;
            4'd2:  r = 21'sd16055;
            4'd3:  r = 21'sd8150;
            4'd4:  r = 21'sd4091;
            4'd5:  r = 21'sd2047;
            4'd6:  r = 21'sd1024;
            4'd7:  r = 21'sd512;
            4'd8:  r = 21'sd256;
            4'd9:  r = 21'sd128;
            4'd10: r = 21'sd64;
            4'd11: r = 21'sd32;
            4'd12: r = 21'sd16;
            4'd13: r = 21'sd8;
            4'd14: r = 21'sd4;
            default: r = 21'sd2;
        endcase
        return r;
    endfunction

endpackage

### rtl/core/lfkj_cordic.sv
// Pipelined rotation CORDIC: sine and cosine of one Q2.13 angle in Q1.15.
// Depends on lfkj_pkg.
module lfkj_cordic (
    input  logic                clk,
    input  logic                en,
    input  logic signed [15:0]  ang,
    output lfkj_pkg::trig_t     trig
);
    import lfkj_pkg::*;

    logic signed [33:0] x_reg [0:CordicSteps];
    logic signed [33:0] y_reg [0:CordicSteps];
    logic signed [20:0] z_reg [0:CordicSteps];
    logic               flip_reg [0:CordicSteps];
    trig_t              trig_reg;

    logic signed [20:0] z_in;
    logic signed [20:0] z_next;
    logic               flip_next;

    // Fold the angle into plus or minus pi/2
    always_comb
    begin
        z_in = 21'(ang) <<< 3;
        z_next = z_in;
        flip_next = 1'b0;
        if (z_in > AngHalfPi)
        begin
            z_next = z_in - AngPi;
            flip_next = 1'b1;
        end
        else if (z_in < -AngHalfPi)
        begin
            z_next = z_in + AngPi;
            flip_next = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0]    <= CordicGain;
            y_reg[0]    <= '0;
            z_reg[0]    <= z_next;
            flip_reg[0] <= flip_next;
        end
    end

    // One micro-rotation per stage
    for (genvar i = 0; i < CordicSteps; i++)
    begin : g_step
        logic signed [33:0] dx;
        logic signed [33:0] dy;
        assign dx = y_reg[i] >>> i;
        assign dy = x_reg[i] >>> i;
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                flip_reg[i+1] <= flip_reg[i];
                if (!z_reg[i][20])
                begin
                    x_reg[i+1] <= x_reg[i] - dx;
                    y_reg[i+1] <= y_reg[i] + dy;
                    z_reg[i+1] <= z_reg[i] - atan_step(4'(i));
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] + dx;
                    y_reg[i+1] <= y_reg[i] - dy;
                    z_reg[i+1] <= z_reg[i] + atan_step(4'(i));
                end
            end
        end
    end

    // Undo the fold, round to Q15 and clamp
    logic signed [33:0] xf, yf, xr, yr;
    trig_t              trig_next;

    always_comb
    begin
        xf = flip_reg[CordicSteps] ? -x_reg[CordicSteps] : x_reg[CordicSteps];
        yf = flip_reg[CordicSteps] ? -y_reg[CordicSteps] : y_reg[CordicSteps];
        xr = (xf + 34'sd16384) >>> 15;
        yr = (yf + 34'sd16384) >>> 15;
        if (xr > 34'sd32767)
            trig_next.cs = 16'sd32767;
        else if (xr < -34'sd32768)
            trig_next.cs = -16'sd32768;
        else
            trig_next.cs = 16'(xr);
        if (yr > 34'sd32767)
            trig_next.sn = 16'sd32767;
        else if (yr < -34'sd32768)
            trig_next.sn = -16'sd32768;
        else
            trig_next.sn = 16'(yr);
    end

    always_ff @(posedge clk)
    begin
        if (en)
            trig_reg <= trig_next;
    end

    assign trig = trig_reg;

endmodule

### rtl/core/lfkj_kin.sv
// Six-stage multiply and round pipeline from joint trig values to results.
// Depends on lfkj_pkg.
module lfkj_kin (
    input  logic                  clk,
    input  logic                  en,
    input  lfkj_pkg::geom_t       geom,
    input  lfkj_pkg::trig_t       t1,
    input  lfkj_pkg::trig_t       t2,
    input  lfkj_pkg::trig_t       t3,
    output lfkj_pkg::out_beat_t   res
);
    import lfkj_pkg::*;

    // Stage 1: angle-sum products
    logic signed [31:0] psc_reg, pcs_reg, pcc_reg, pss_reg;
    trig_t              t1a_reg, t2a_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            psc_reg <= 32'(t2.sn) * 32'(t3.cs);
            pcs_reg <= 32'(t2.cs) * 32'(t3.sn);
            pcc_reg <= 32'(t2.cs) * 32'(t3.cs);
            pss_reg <= 32'(t2.sn) * 32'(t3.sn);
            t1a_reg <= t1;
            t2a_reg <= t2;
        end
    end

    // Stage 2: s23 and c23
    logic signed [31:0] r_sc, r_cs, r_cc, r_ss;
    logic signed [17:0] s23_reg, c23_reg;
    trig_t              t1b_reg, t2b_reg;

    always_comb
    begin
        r_sc = (psc_reg + 32'sd16384) >>> 15;
        r_cs = (pcs_reg + 32'sd16384) >>> 15;
        r_cc = (pcc_reg + 32'sd16384) >>> 15;
        r_ss = (pss_reg + 32'sd16384) >>> 15;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s23_reg <= 18'(r_sc + r_cs);
            c23_reg <= 18'(r_cc - r_ss);
            t1b_reg <= t1a_reg;
            t2b_reg <= t2a_reg;
        end
    end

    // Stage 3: link-length products
    logic signed [39:0] m_ts_reg, m_ss_reg, m_tc_reg, m_sc_reg;
    trig_t              t1c_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_ts_reg <= 40'(geom.thigh_length) * 40'(t2b_reg.sn);
            m_ss_reg <= 40'(geom.shank_length) * 40'(s23_reg);
            m_tc_reg <= 40'(geom.thigh_length) * 40'(t2b_reg.cs);
            m_sc_reg <= 40'(geom.shank_length) * 40'(c23_reg);
            t1c_reg  <= t1b_reg;
        end
    end

    // Stage 4: A, B, C, D
    logic signed [39:0] a_w, b_w, c_w, d_w;
    logic signed [23:0] a_reg, b_reg, c_reg, d_reg;
    trig_t              t1d_reg;

    always_comb
    begin
        a_w = (m_ts_reg + m_ss_reg + 40'sd16384) >>> 15;
        b_w = (m_tc_reg + m_sc_reg + 40'sd16384) >>> 15;
        c_w = (m_sc_reg + 40'sd16384) >>> 15;
        d_w = (m_ss_reg + 40'sd16384) >>> 15;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_reg   <= 24'(a_w);
            b_reg   <= 24'(b_w);
            c_reg   <= 24'(c_w);
            d_reg   <= 24'(d_w);
            t1d_reg <= t1c_reg;
        end
    end

    // Stage 5: hip-yaw products
    logic signed [39:0] ds1_reg, ac1_reg, as1_reg, dc1_reg;
    logic signed [39:0] bc1_reg, cc1_reg, bs1_reg, cs1_reg;
    logic signed [23:0] fz_reg, na_reg, nd_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ds1_reg <= 40'(geom.side_offset) * 40'(t1d_reg.sn);
            dc1_reg <= 40'(geom.side_offset) * 40'(t1d_reg.cs);
            ac1_reg <= 40'(a_reg) * 40'(t1d_reg.cs);
            as1_reg <= 40'(a_reg) * 40'(t1d_reg.sn);
            bc1_reg <= 40'(b_reg) * 40'(t1d_reg.cs);
            bs1_reg <= 40'(b_reg) * 40'(t1d_reg.sn);
            cc1_reg <= 40'(c_reg) * 40'(t1d_reg.cs);
            cs1_reg <= 40'(c_reg) * 40'(t1d_reg.sn);
            fz_reg  <= 24'(25'(geom.base_height) + 25'(geom.upper_offset) + 25'(b_reg));
            na_reg  <= -a_reg;
            nd_reg  <= -d_reg;
        end
    end

    // Stage 6: final sums and rounding into the output register
    logic signed [41:0] fx_w, fy_w, j11_w, j12_w, j13_w, j22_w, j23_w;
    out_beat_t          res_reg, res_next;

    always_comb
    begin
        fx_w  = (42'(ds1_reg) - 42'(ac1_reg) + 42'sd16384) >>> 15;
        fy_w  = (-42'(as1_reg) - 42'(dc1_reg) + 42'sd16384) >>> 15;
        j11_w = (42'(as1_reg) + 42'(dc1_reg) + 42'sd16384) >>> 15;
        j12_w = (-42'(bc1_reg) + 42'sd16384) >>> 15;
        j13_w = (-42'(cc1_reg) + 42'sd16384) >>> 15;
        j22_w = (-42'(bs1_reg) + 42'sd16384) >>> 15;
        j23_w = (-42'(cs1_reg) + 42'sd16384) >>> 15;
        res_next.foot_x   = 24'(fx_w);
        res_next.foot_y   = 24'(fy_w);
        res_next.foot_z   = fz_reg;
        res_next.jac_r1c1 = 24'(j11_w);
        res_next.jac_r1c2 = 24'(j12_w);
        res_next.jac_r1c3 = 24'(j13_w);
        res_next.jac_r2c1 = 24'(fx_w);
        res_next.jac_r2c2 = 24'(j22_w);
        res_next.jac_r2c3 = 24'(j23_w);
        res_next.jac_r3c2 = na_reg;
        res_next.jac_r3c3 = nd_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            res_reg <= res_next;
    end

    assign res = res_reg;

endmodule

### rtl/core/leg_forward_kinematics_jacobian.sv
// Three-joint leg forward kinematics and position Jacobian. The three parallel
// 16-step CORDIC pipelines feed the multiply and round pipeline; one beat is
// accepted every cycle unless a finished result is stalled at the output, and then
// the whole pipeline holds. Depends on lfkj_pkg.
module leg_forward_kinematics_jacobian (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  lfkj_pkg::in_beat_t    in_data,
    output logic                  out_valid,
    input  logic                  out_stall,
    output lfkj_pkg::out_beat_t   out_data,
    input  logic                  cfg_we,
    input  logic [2:0]            cfg_index,
    input  logic [19:0]           cfg_data
);
    import lfkj_pkg::*;

    localparam int Lat = TrigLat + KinLat;

    geom_t          geom_reg;
    logic [Lat-1:0] vld_reg;
    logic           adv;
    trig_t          t1, t2, t3;

    // Geometry registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            geom_reg <= '0;
        else if (cfg_we)
        begin
            unique case (cfg_index)
                RegBaseHeight:  geom_reg.base_height  <= cfg_data;
                RegUpperOffset: geom_reg.upper_offset <= cfg_data;
                RegSideOffset:  geom_reg.side_offset  <= cfg_data;
                RegThighLength: geom_reg.thigh_length <= cfg_data;
                RegShankLength: geom_reg.shank_length <= cfg_data;
                default: ;
            endcase
        end
    end

    // Pipeline advances unless the last beat is held
    assign adv      = !(vld_reg[Lat-1] && out_stall);
    assign in_stall = !adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[Lat-2:0], in_valid};
    end

    lfkj_cordic u_cordic_hip (.clk(clk), .en(adv), .ang(in_data.hip_angle),   .trig(t1));
    lfkj_cordic u_cordic_pit (.clk(clk), .en(adv), .ang(in_data.pitch_angle), .trig(t2));
    lfkj_cordic u_cordic_kne (.clk(clk), .en(adv), .ang(in_data.knee_angle),  .trig(t3));

    lfkj_kin u_kin (
        .clk  (clk),
        .en   (adv),
        .geom (geom_reg),
        .t1   (t1),
        .t2   (t2),
        .t3   (t3),
        .res  (out_data)
    );

    assign out_valid = vld_reg[Lat-1];

`include "leg_forward_kinematics_jacobian_defines.svh"

    `LFKJ_ASSERT_NOW(a_stall_only_on_hold, clk, rst_n, in_stall, out_valid && out_stall, "input stalled without held output")
    `LFKJ_ASSERT_NEXT(a_accept_enters, clk, rst_n, in_valid && !in_stall, vld_reg[0], "accepted beat lost at entry")
    `LFKJ_ASSERT_NEXT(a_hold_freezes, clk, rst_n, !adv, $stable(vld_reg), "valid pipeline moved while held")

endmodule

### tb/tb.sv
// Testbench for leg_forward_kinematics_jacobian: drives joint-angle beats,
// predicts foot position and Jacobian in fixed point, checks every result beat.
// Depends on lfkj_pkg and the block's RTL.
`timescale 1ns / 100ps

// Holds predicted kinematics results and compares them with block output
class kin_scoreboard;
    lfkj_pkg::geom_t geom;
    lfkj_pkg::out_beat_t pending_q[$];
    int mismatches;

    function new();
        geom = '0;
        mismatches = 0;
    endfunction

    static function longint floor_shr(longint v, int s);
        return v >>> s;
    endfunction

    static function longint rnd15(longint v);
        return floor_shr(v + 16384, 15);
    endfunction

    static function longint clamp15(longint v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    // Integer CORDIC sine and cosine of a Q2.13 angle
    static function void sin_cos(logic signed [15:0] ang, output longint sn,
                                 output longint cs);
        longint z, x, y, dx, dy;
        bit flip;
        longint atans[16];
        atans = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                  256, 128, 64, 32, 16, 8, 4, 2};
        z = longint'(ang) * 8;
        x = 652032874;
        y = 0;
        flip = 0;
        if (z > 102944)
        begin
            z -= 205887;
            flip = 1;
        end
        else if (z < -102944)
        begin
            z += 205887;
            flip = 1;
        end
        for (int i = 0; i < 16; i++)
        begin
            dx = floor_shr(y, i);
            dy = floor_shr(x, i);
            if (z >= 0)
            begin
                x -= dx; y += dy; z -= atans[i];
            end
            else
            begin
                x += dx; y -= dy; z += atans[i];
            end
        end
        if (flip)
        begin
            x = -x; y = -y;
        end
        cs = clamp15(rnd15(x));
        sn = clamp15(rnd15(y));
    endfunction

    function void write_reg(logic [2:0] idx, logic [19:0] val);
        case (idx)
            lfkj_pkg::RegBaseHeight:  geom.base_height = val;
            lfkj_pkg::RegUpperOffset: geom.upper_offset = val;
            lfkj_pkg::RegSideOffset:  geom.side_offset = val;
            lfkj_pkg::RegThighLength: geom.thigh_length = val;
            lfkj_pkg::RegShankLength: geom.shank_length = val;
            default: ;
        endcase
    endfunction

    // Predict the result of one accepted input beat
    function void note_angles(lfkj_pkg::in_beat_t b);
        longint s1, c1, s2, c2, s3, c3, s23, c23, a, bb, c, d, l0, l1, d2, l2, l3;
        lfkj_pkg::out_beat_t r;
        sin_cos(b.hip_angle, s1, c1);
        sin_cos(b.pitch_angle, s2, c2);
        sin_cos(b.knee_angle, s3, c3);
        l0 = longint'(geom.base_height); l1 = longint'(geom.upper_offset);
        d2 = longint'(geom.side_offset);
        l2 = longint'(geom.thigh_length); l3 = longint'(geom.shank_length);
        s23 = rnd15(s2 * c3) + rnd15(c2 * s3);
        c23 = rnd15(c2 * c3) - rnd15(s2 * s3);
        a = rnd15(l2 * s2 + l3 * s23);
        bb = rnd15(l2 * c2 + l3 * c23);
        c = rnd15(l3 * c23);
        d = rnd15(l3 * s23);
        r.foot_x = 24'(rnd15(d2 * s1 - a * c1));
        r.foot_y = 24'(rnd15(-(a * s1) - d2 * c1));
        r.foot_z = 24'(l0 + l1 + bb);
        r.jac_r1c1 = 24'(rnd15(a * s1 + d2 * c1));
        r.jac_r1c2 = 24'(rnd15(-(bb * c1)));
        r.jac_r1c3 = 24'(rnd15(-(c * c1)));
        r.jac_r2c1 = r.foot_x;
        r.jac_r2c2 = 24'(rnd15(-(bb * s1)));
        r.jac_r2c3 = 24'(rnd15(-(c * s1)));
        r.jac_r3c2 = 24'(-a);
        r.jac_r3c3 = 24'(-d);
        pending_q.push_back(r);
    endfunction

    function void check_result(lfkj_pkg::out_beat_t got);
        lfkj_pkg::out_beat_t exp_r;
        if (pending_q.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected result beat %h", got);
            return;
        end
        exp_r = pending_q.pop_front();
        if (got !== exp_r)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch: expected %h actual %h", exp_r, got);
        end
    endfunction
endclass

module tb;
    import lfkj_pkg::*;

    localparam int Latency = TrigLat + KinLat;
    localparam longint CycleLimit = 400000;

    logic clk = 0;
    logic rst_n = 0;
    logic in_valid = 0;
    logic in_stall;
    in_beat_t in_data = '0;
    logic out_valid;
    logic out_stall = 0;
    out_beat_t out_data;
    logic cfg_we = 0;
    logic [2:0] cfg_index = '0;
    logic [19:0] cfg_data = '0;

    kin_scoreboard sb = new();
    longint cycles = 0;
    int hold_cycles = 0;     // forced receiver hold-off
    bit calm = 0;            // stretch with no random idling

    leg_forward_kinematics_jacobian dut (.*);

    always #5 clk = ~clk;

    // Cycle limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Result checking at the rising edge
    always @(posedge clk)
        if (rst_n && out_valid && !out_stall)
            sb.check_result(out_data);

    // Receiver stall, changed at the falling edge
    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            out_stall <= 1;
            hold_cycles <= hold_cycles - 1;
        end
        else
            out_stall <= !calm && ($urandom_range(99) < 9);
    end

    function automatic logic [15:0] rand_angle();
        case ($urandom_range(3))
            0: return 16'($urandom_range(25736 * 2) - 25736);
            1: return 16'($urandom_range(32767 * 2 + 1) - 32768);
            2: return 16'($urandom_range(16) - 8);
            default: return $urandom_range(1) ? 16'(12868 + $urandom_range(8) - 4)
                                              : 16'(-12868 + $urandom_range(8) - 4);
        endcase
    endfunction

    // Send one beat, with random idle before it; valid stays up for the next beat
    task automatic send_angles(logic [15:0] h, logic [15:0] p, logic [15:0] k);
        while (!calm && $urandom_range(99) < 9)
        begin
            in_valid <= 0;
            @(negedge clk);
        end
        in_valid <= 1;
        in_data <= {h, p, k};
        do
            @(posedge clk);
        while (in_stall);
        sb.note_angles(in_data);
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid <= 0;
        while (sb.pending_q.size() != 0)
            @(negedge clk);
        repeat (Latency + 4) @(negedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [19:0] val);
        cfg_we <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        sb.write_reg(idx, val);
        @(negedge clk);
        cfg_we <= 0;
        @(negedge clk);
    endtask

    task automatic set_geometry(int mode);
        for (int r = 0; r < 5; r++)
        begin
            case (mode)
                0: write_reg(3'(r), 20'h7FFFF);
                1: write_reg(3'(r), 20'h80000);
                default: write_reg(3'(r), 20'($urandom()));
            endcase
        end
    endtask

    task automatic random_batch(int n);
        for (int i = 0; i < n; i++)
            send_angles(rand_angle(), rand_angle(), rand_angle());
    endtask

    initial
    begin
        logic [15:0] corner[7];
        corner = '{16'sd0, 16'sd25736, -16'sd25736, 16'sd32767, -16'sd32768,
                   16'sd12868, -16'sd12869};
        repeat (8) @(negedge clk);
        rst_n <= 1;
        @(negedge clk);

        // Directed: realistic geometry, angle extremes and quadrant edges
        write_reg(RegBaseHeight, 20'sd6554);
        write_reg(RegUpperOffset, -20'sd3277);
        write_reg(RegSideOffset, 20'sd5243);
        write_reg(RegThighLength, 20'sd13107);
        write_reg(RegShankLength, 20'sd13107);
        write_reg(3'd5, 20'h12345);     // out-of-range index is ignored
        write_reg(3'd7, 20'h54321);
        for (int i = 0; i < 7; i++)
            send_angles(corner[i], corner[(i + 2) % 7], corner[(i + 4) % 7]);
        drain();
        set_geometry(0);
        for (int i = 0; i < 7; i++)
            send_angles(corner[i], corner[i], corner[(i + 1) % 7]);
        drain();
        set_geometry(1);
        for (int i = 0; i < 7; i++)
            send_angles(corner[(i + 3) % 7], corner[i], corner[i]);
        drain();

        // Random phases across geometry settings
        for (int ph = 0; ph < 6; ph++)
        begin
            set_geometry(ph < 2 ? ph : 2);
            calm = (ph == 3);
            if (ph == 4)
                hold_cycles = 200;    // fill the pipeline and back up the input
            random_batch(230);
            calm = 0;
            drain();                  // sender waits for every result
        end

        if (sb.mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule

### leg_forward_kinematics_jacobian.f
+incdir+rtl/core
rtl/core/lfkj_pkg.sv
rtl/core/lfkj_cordic.sv
rtl/core/lfkj_kin.sv
rtl/core/leg_forward_kinematics_jacobian.sv
tb/tb.sv
